// ----- rtl/core/qgm_pkg.sv -----
// Shared types, constants and tables for the single-qubit gate matrix generator.
package qgm_pkg;

    // Defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int ENTRY_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 14;

    // CORDIC datapath widths (Q30 rotation vector, 2^-32 turn residual)
    localparam int CW = 34;
    localparam int ZW = 32;

    localparam longint GAIN_Q30      = 64'sd652032874;
    localparam longint INV_SQRT2_Q30 = 64'sd759250125;

    // Gate codes
    localparam logic [3:0] OP_X    = 4'd0;
    localparam logic [3:0] OP_Y    = 4'd1;
    localparam logic [3:0] OP_Z    = 4'd2;
    localparam logic [3:0] OP_H    = 4'd3;
    localparam logic [3:0] OP_S    = 4'd4;
    localparam logic [3:0] OP_T    = 4'd5;
    localparam logic [3:0] OP_RX   = 4'd6;
    localparam logic [3:0] OP_RY   = 4'd7;
    localparam logic [3:0] OP_RZ   = 4'd8;
    localparam logic [3:0] OP_CX   = 4'd9;
    localparam logic [3:0] OP_CZ   = 4'd10;
    localparam logic [3:0] OP_SWAP = 4'd11;

    // Error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_TWO_QUBIT = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd2;

    // arctan(2^-i) in 2^-32 turn units
    localparam logic signed [ZW-1:0] ATAN_TURNS [30] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1
    };

    // Transaction payload as it travels along the CORDIC chain
    typedef struct packed {
        logic [3:0]           op;
        logic [1:0]           quad;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] r;
    } cordic_data_t;

endpackage

// ----- rtl/core/qgm_cordic_cell.sv -----
// One CORDIC micro-rotation cell with its own pipeline register and flow control.
module qgm_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  qgm_pkg::cordic_data_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output qgm_pkg::cordic_data_t dn_data
);

    logic                  valid_reg;
    qgm_pkg::cordic_data_t data_reg;
    qgm_pkg::cordic_data_t data_next;
    logic signed [qgm_pkg::CW-1:0] dx;
    logic signed [qgm_pkg::CW-1:0] dy;
    logic signed [qgm_pkg::ZW-1:0] atan_val;

    assign atan_val = qgm_pkg::ATAN_TURNS[SHIFT];
    // arithmetic shift = floor division
    assign dx = up_data.y >>> SHIFT;
    assign dy = up_data.x >>> SHIFT;

    always_comb
    begin
        data_next = up_data;
        if (!up_data.r[qgm_pkg::ZW-1])
        begin
            data_next.x = up_data.x - dx;
            data_next.y = up_data.y + dy;
            data_next.r = up_data.r - atan_val;
        end
        else
        begin
            data_next.x = up_data.x + dx;
            data_next.y = up_data.y - dy;
            data_next.r = up_data.r + atan_val;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- rtl/core/qgm_matrix_out.sv -----
// Rounding, quadrant fold and matrix assembly, with the output register.
module qgm_matrix_out #(
    parameter int ENTRY_BITS = qgm_pkg::ENTRY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  qgm_pkg::cordic_data_t        up_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ENTRY_BITS-1:0] m00_re,
    output logic signed [ENTRY_BITS-1:0] m00_im,
    output logic signed [ENTRY_BITS-1:0] m01_re,
    output logic signed [ENTRY_BITS-1:0] m01_im,
    output logic signed [ENTRY_BITS-1:0] m10_re,
    output logic signed [ENTRY_BITS-1:0] m10_im,
    output logic signed [ENTRY_BITS-1:0] m11_re,
    output logic signed [ENTRY_BITS-1:0] m11_im,
    output logic [1:0]                   error_code,
    output logic                         is_diagonal,
    output logic                         two_qubit
);

    localparam int FRAC = ENTRY_BITS - 2;
    localparam int SH   = 30 - FRAC;
    localparam longint ROUND64 = (64'sd1 <<< SH) >>> 1;
    localparam logic signed [qgm_pkg::CW-1:0] ROUND = qgm_pkg::CW'(ROUND64);
    localparam logic signed [qgm_pkg::CW-1:0] ONE_W = qgm_pkg::CW'(64'sd1 <<< FRAC);
    localparam logic signed [ENTRY_BITS-1:0] ONE = ENTRY_BITS'(64'sd1 <<< FRAC);
    localparam logic signed [ENTRY_BITS-1:0] H_E =
        ENTRY_BITS'((qgm_pkg::INV_SQRT2_Q30 + ROUND64) >>> SH);

    logic signed [qgm_pkg::CW-1:0] xr, yr, xs, ys;
    logic signed [ENTRY_BITS-1:0]  xe, ye, c, s;
    logic signed [ENTRY_BITS-1:0]  m_next [8];
    logic [1:0] err_next;
    logic       diag_next, two_next;

    logic                         valid_reg;
    logic signed [ENTRY_BITS-1:0] m_reg [8];
    logic [1:0]                   err_reg;
    logic                         diag_reg, two_reg;

    // round half up, saturate to +-one
    always_comb
    begin
        xr = (up_data.x + ROUND) >>> SH;
        yr = (up_data.y + ROUND) >>> SH;
        xs = (xr > ONE_W) ? ONE_W : ((xr < -ONE_W) ? -ONE_W : xr);
        ys = (yr > ONE_W) ? ONE_W : ((yr < -ONE_W) ? -ONE_W : yr);
        xe = xs[ENTRY_BITS-1:0];
        ye = ys[ENTRY_BITS-1:0];
        case (up_data.quad)
            2'd0:    begin c = xe;  s = ye;  end
            2'd1:    begin c = -ye; s = xe;  end
            2'd2:    begin c = -xe; s = -ye; end
            default: begin c = ye;  s = -xe; end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < 8; j++)
            m_next[j] = '0;
        err_next  = qgm_pkg::ERR_OK;
        diag_next = 1'b0;
        two_next  = 1'b0;
        unique case (up_data.op) inside
            qgm_pkg::OP_X:
            begin
                m_next[2] = ONE; m_next[4] = ONE;
            end
            qgm_pkg::OP_Y:
            begin
                m_next[3] = -ONE; m_next[5] = ONE;
            end
            qgm_pkg::OP_Z:
            begin
                m_next[0] = ONE; m_next[6] = -ONE; diag_next = 1'b1;
            end
            qgm_pkg::OP_H:
            begin
                m_next[0] = H_E; m_next[2] = H_E; m_next[4] = H_E; m_next[6] = -H_E;
            end
            qgm_pkg::OP_S:
            begin
                m_next[0] = ONE; m_next[7] = ONE; diag_next = 1'b1;
            end
            qgm_pkg::OP_T:
            begin
                m_next[0] = ONE; m_next[6] = H_E; m_next[7] = H_E; diag_next = 1'b1;
            end
            qgm_pkg::OP_RX:
            begin
                m_next[0] = c; m_next[3] = -s; m_next[5] = -s; m_next[6] = c;
            end
            qgm_pkg::OP_RY:
            begin
                m_next[0] = c; m_next[2] = -s; m_next[4] = s; m_next[6] = c;
            end
            qgm_pkg::OP_RZ:
            begin
                m_next[0] = c; m_next[1] = -s; m_next[6] = c; m_next[7] = s;
                diag_next = 1'b1;
            end
            qgm_pkg::OP_CX, qgm_pkg::OP_SWAP:
            begin
                err_next = qgm_pkg::ERR_TWO_QUBIT; two_next = 1'b1;
            end
            qgm_pkg::OP_CZ:
            begin
                err_next = qgm_pkg::ERR_TWO_QUBIT; two_next = 1'b1; diag_next = 1'b1;
            end
            default:
            begin
                err_next = qgm_pkg::ERR_UNKNOWN;
            end
        endcase
    end

    assign up_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            m_reg    <= m_next;
            err_reg  <= err_next;
            diag_reg <= diag_next;
            two_reg  <= two_next;
        end
    end

    assign out_valid   = valid_reg;
    assign m00_re      = m_reg[0];
    assign m00_im      = m_reg[1];
    assign m01_re      = m_reg[2];
    assign m01_im      = m_reg[3];
    assign m10_re      = m_reg[4];
    assign m10_im      = m_reg[5];
    assign m11_re      = m_reg[6];
    assign m11_im      = m_reg[7];
    assign error_code  = err_reg;
    assign is_diagonal = diag_reg;
    assign two_qubit   = two_reg;

endmodule

// ----- rtl/core/qubit_gate_matrix_generator_core.sv -----
// Top level of the single-qubit gate matrix generator: CORDIC cell chain and output stage.
//
// Usage
//   Input channel (in_valid / in_stall): one transaction carries a gate code (op) and a
//   signed binary angle (angle, full range = 4 pi, so the half angle spans one turn).
//   Output channel (out_valid / out_stall): one transaction per input, in order, carrying
//   the 2x2 complex unitary in signed Q1.14 (at the default ENTRY_BITS), error_code,
//   is_diagonal and two_qubit.
//   Every gate, rotation or not, passes through the same chain so order is kept.
//
// Pipelining and throughput
//   Each CORDIC cell has its own register, followed by the rounding/assembly register.
//   A new transaction is taken every cycle while in_stall is low; the chain of
//   CORDIC_STAGES cells plus the output register holds up to CORDIC_STAGES + 1 in flight.
//
// Reset and back-pressure
//   rst_n clears every stage's valid flag; the pipeline comes up empty and ready.
//   When out_stall holds a result, each cell still advances into any empty slot ahead
//   of it, so bubbles collapse; in_stall rises only once the whole chain is full.
//   The result register holds steady while stalled.
module qubit_gate_matrix_generator_core #(
    parameter int ANGLE_BITS    = qgm_pkg::ANGLE_BITS_DEF,
    parameter int ENTRY_BITS    = qgm_pkg::ENTRY_BITS_DEF,
    parameter int CORDIC_STAGES = qgm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [3:0]                   op,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ENTRY_BITS-1:0] m00_re,
    output logic signed [ENTRY_BITS-1:0] m00_im,
    output logic signed [ENTRY_BITS-1:0] m01_re,
    output logic signed [ENTRY_BITS-1:0] m01_im,
    output logic signed [ENTRY_BITS-1:0] m10_re,
    output logic signed [ENTRY_BITS-1:0] m10_im,
    output logic signed [ENTRY_BITS-1:0] m11_re,
    output logic signed [ENTRY_BITS-1:0] m11_im,
    output logic [1:0]                   error_code,
    output logic                         is_diagonal,
    output logic                         two_qubit
);

    // half angle placed in a 32-bit turn word
    localparam int TURN_SHIFT = 32 - ANGLE_BITS;

    logic [31:0]           turn;
    logic                  chain_valid [CORDIC_STAGES+1];
    logic                  chain_ready [CORDIC_STAGES+1];
    qgm_pkg::cordic_data_t chain_data  [CORDIC_STAGES+1];

    // top two bits give the quadrant, the rest is rotated (0 .. quarter turn)
    assign turn = 32'(unsigned'(angle)) << TURN_SHIFT;

    always_comb
    begin
        chain_data[0].op   = op;
        chain_data[0].quad = turn[31:30];
        chain_data[0].x    = qgm_pkg::CW'(qgm_pkg::GAIN_Q30);
        chain_data[0].y    = '0;
        chain_data[0].r    = qgm_pkg::ZW'({2'b00, turn[29:0]});
    end

    assign chain_valid[0] = in_valid;
    assign in_stall       = !chain_ready[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        qgm_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    qgm_matrix_out #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (chain_valid[CORDIC_STAGES]),
        .up_ready    (chain_ready[CORDIC_STAGES]),
        .up_data     (chain_data[CORDIC_STAGES]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .m00_re      (m00_re),
        .m00_im      (m00_im),
        .m01_re      (m01_re),
        .m01_im      (m01_im),
        .m10_re      (m10_re),
        .m10_im      (m10_im),
        .m11_re      (m11_re),
        .m11_im      (m11_im),
        .error_code  (error_code),
        .is_diagonal (is_diagonal),
        .two_qubit   (two_qubit)
    );

endmodule

// ----- rtl/core/qgm_checker.sv -----
// Port-level assertions for the gate matrix generator, bound to the top level.
module qgm_checker #(
    parameter int ANGLE_BITS    = qgm_pkg::ANGLE_BITS_DEF,
    parameter int ENTRY_BITS    = qgm_pkg::ENTRY_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [3:0]                   op,
    input logic signed [ANGLE_BITS-1:0] angle,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [ENTRY_BITS-1:0] m00_re,
    input logic signed [ENTRY_BITS-1:0] m00_im,
    input logic signed [ENTRY_BITS-1:0] m01_re,
    input logic signed [ENTRY_BITS-1:0] m01_im,
    input logic signed [ENTRY_BITS-1:0] m10_re,
    input logic signed [ENTRY_BITS-1:0] m10_im,
    input logic signed [ENTRY_BITS-1:0] m11_re,
    input logic signed [ENTRY_BITS-1:0] m11_im,
    input logic [1:0]                   error_code,
    input logic                         is_diagonal,
    input logic                         two_qubit
);

    // stalled input transaction is held by the sender
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(op) && $stable(angle))
        else $error("input changed while stalled");

    // held result stays put (checked on m00_re, m11_im and error_code)
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(m00_re) && $stable(m11_im)
            && $stable(error_code))
        else $error("output changed while stalled");

    // an empty output register means the chain can take a transaction
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // two-qubit gates give zero entries and their error code
    a_two_qubit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && two_qubit |-> error_code == qgm_pkg::ERR_TWO_QUBIT
            && m00_re == '0 && m01_re == '0 && m10_re == '0 && m11_re == '0
            && m00_im == '0 && m01_im == '0 && m10_im == '0 && m11_im == '0)
        else $error("two-qubit result malformed");

    // unknown opcodes raise no flags
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == qgm_pkg::ERR_UNKNOWN |-> !is_diagonal && !two_qubit)
        else $error("unknown opcode flagged");

endmodule

bind qubit_gate_matrix_generator_core qgm_checker #(
    .ANGLE_BITS    (ANGLE_BITS),
    .ENTRY_BITS    (ENTRY_BITS)
) u_qgm_checker (.*);
